@@ sv/atl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_pkg
// Shared constants, register indexes and types of the tilt angle core.
// ----------------------------------------------------------------------------
package atl_pkg;

    // Register indexes of the configuration port.
    localparam logic REG_CAL_LOW  = 1'b0;
    localparam logic REG_CAL_HIGH = 1'b1;

    // Reset values of the calibration registers.
    localparam int CAL_LOW_RESET  = 265;
    localparam int CAL_HIGH_RESET = 402;

    // Angles are kept in degrees with 16 fractional bits.
    localparam int FRAC  = 16;
    localparam int ZW    = 25;
    localparam int TW    = 25;
    localparam int ANG_W = 9;
    localparam int TAB_LEN = 24;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    localparam logic [22:0] ATAN_Q16 [0:TAB_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379,
        23'd117304, 23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667,
        23'd1833, 23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

    // Quadrant and special case marks that travel beside the CORDIC data.
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
        logic equal;
    } tilt_ctl_t;

endpackage

@@ sv/atl_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_div_cell
// One restoring division step: settles one quotient bit per cell.
// ----------------------------------------------------------------------------
module atl_div_cell import atl_pkg::*; #(
    parameter int SB = 10,
    parameter int QW = 18
) (
    input  logic          clk,
    input  logic          en,
    input  logic [SB-1:0] span,
    input  logic [QW-1:0] num_in,
    input  logic [SB-1:0] rem_in,
    input  logic [QW-1:0] quo_in,
    input  logic          neg_in,
    output logic [QW-1:0] num_out,
    output logic [SB-1:0] rem_out,
    output logic [QW-1:0] quo_out,
    output logic          neg_out
);

    logic [SB:0]   trial;
    logic          fits;
    logic [SB-1:0] rem_next;
    logic [QW-1:0] num_reg, quo_reg;
    logic [SB-1:0] rem_reg;
    logic          neg_reg;

    // Bring down the next numerator bit and try the subtraction.
    always_comb
    begin
        trial    = {rem_in, num_in[QW-1]};
        fits     = (trial >= {1'b0, span});
        rem_next = fits ? SB'(trial - {1'b0, span}) : trial[SB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= {num_in[QW-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_in[QW-2:0], fits};
            neg_reg <= neg_in;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign neg_out = neg_reg;

endmodule

@@ sv/atl_axis_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_axis_map
// Maps a raw reading via divider cells: cal_low to -90, cal_low + span to 90.
// ----------------------------------------------------------------------------
module atl_axis_map import atl_pkg::*; #(
    parameter int SB = 10,
    parameter int QW = SB + 8,
    parameter int AW = SB + 10
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [SB-1:0]        raw,
    input  logic [SB-1:0]        cal_low,
    input  logic [SB-1:0]        span,
    output logic signed [AW-1:0] mapped
);

    logic signed [SB:0]   diff;
    logic signed [SB+8:0] prod;
    logic [QW-1:0] num_reg;
    logic          neg_reg;
    logic [QW-1:0] num_c [0:QW];
    logic [SB-1:0] rem_c [0:QW];
    logic [QW-1:0] quo_c [0:QW];
    logic          neg_c [0:QW];
    logic signed [AW-1:0] mapped_reg, sq;

    // Offset and scale by 180; the sign is kept apart for truncation to zero.
    always_comb
    begin
        diff = signed'({1'b0, raw}) - signed'({1'b0, cal_low});
        prod = (SB+9)'(diff) * (SB+9)'(180);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= prod[SB+8] ? QW'(-prod) : QW'(prod);
            neg_reg <= prod[SB+8];
        end
    end

    assign num_c[0] = num_reg;
    assign rem_c[0] = '0;
    assign quo_c[0] = '0;
    assign neg_c[0] = neg_reg;

    // Row of division cells, one quotient bit each.
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        atl_div_cell #(.SB(SB), .QW(QW)) u_cell (
            .clk(clk), .en(en), .span(span),
            .num_in(num_c[k]), .rem_in(rem_c[k]), .quo_in(quo_c[k]),
            .neg_in(neg_c[k]),
            .num_out(num_c[k+1]), .rem_out(rem_c[k+1]), .quo_out(quo_c[k+1]),
            .neg_out(neg_c[k+1])
        );
    end

    // Restore the sign and shift down by ninety.
    always_comb
    begin
        sq = signed'(AW'(quo_c[QW]));
        if (neg_c[QW])
        begin
            sq = -sq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mapped_reg <= sq - AW'(90);
        end
    end

    assign mapped = mapped_reg;

endmodule

@@ sv/atl_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_cordic_cell
// One vectoring CORDIC rotation with a fixed shift.
// ----------------------------------------------------------------------------
module atl_cordic_cell import atl_pkg::*; #(
    parameter int STEP = 0,
    parameter int W    = 38
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  tilt_ctl_t            ctl_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output tilt_ctl_t            ctl_out
);

    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q16[STEP]);

    logic signed [W-1:0]  x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg;
    tilt_ctl_t            ctl_reg;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;

    // Rotate toward the x axis.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in > 0)
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + ANG;
            end
            else
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - ANG;
            end
            ctl_reg <= ctl_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign ctl_out = ctl_reg;

endmodule

@@ sv/atl_tilt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_tilt
// floor(atan2(-p, -q) + 180) in degrees through a row of CORDIC cells.
// ----------------------------------------------------------------------------
module atl_tilt import atl_pkg::*; #(
    parameter int AW = 20,
    parameter int N  = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] p,
    input  logic signed [AW-1:0] q,
    output logic [ANG_W-1:0]     angle
);

    localparam int W = AW + FRAC + 2;
    localparam logic signed [ZW-1:0] Q90 = ZW'(90 << FRAC);
    localparam logic [TW-1:0] Q45  = TW'(45 << FRAC);
    localparam logic [TW-1:0] Q180 = TW'(180 << FRAC);
    localparam logic [TW-1:0] Q360 = TW'(360 << FRAC);

    logic signed [AW-1:0] yv, xv;
    logic [AW-1:0] ax, ay;
    logic signed [W-1:0]  x_c [0:N];
    logic signed [W-1:0]  y_c [0:N];
    logic signed [ZW-1:0] z_c [0:N];
    tilt_ctl_t            ctl_c [0:N];
    logic signed [W-1:0]  x0_reg, y0_reg;
    tilt_ctl_t            ctl0_reg, cf;
    logic [TW-1:0]        phi, t;
    logic [ANG_W-1:0]     angle_reg, angle_next;

    // Operands, magnitudes and quadrant marks.
    always_comb
    begin
        yv = -p;
        xv = -q;
        ax = xv[AW-1] ? AW'(-xv) : AW'(xv);
        ay = yv[AW-1] ? AW'(-yv) : AW'(yv);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg         <= signed'(W'(ax)) <<< FRAC;
            y0_reg         <= signed'(W'(ay)) <<< FRAC;
            ctl0_reg.xneg  <= xv[AW-1];
            ctl0_reg.yneg  <= yv[AW-1];
            ctl0_reg.xzero <= (xv == '0);
            ctl0_reg.yzero <= (yv == '0);
            ctl0_reg.equal <= (ax == ay);
        end
    end

    assign x_c[0]   = x0_reg;
    assign y_c[0]   = y0_reg;
    assign z_c[0]   = '0;
    assign ctl_c[0] = ctl0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        atl_cordic_cell #(.STEP(i), .W(W)) u_cell (
            .clk(clk), .en(en),
            .x_in(x_c[i]), .y_in(y_c[i]), .z_in(z_c[i]), .ctl_in(ctl_c[i]),
            .x_out(x_c[i+1]), .y_out(y_c[i+1]), .z_out(z_c[i+1]),
            .ctl_out(ctl_c[i+1])
        );
    end

    // Clamp the angle, restore the quadrant and take the integer part.
    always_comb
    begin
        cf = ctl_c[N];
        if (cf.equal)
        begin
            phi = Q45;
        end
        else if (z_c[N] < 0)
        begin
            phi = '0;
        end
        else if (z_c[N] > Q90)
        begin
            phi = TW'(Q90);
        end
        else
        begin
            phi = TW'(z_c[N]);
        end
        if (!cf.xneg)
        begin
            t = cf.yneg ? Q180 - phi : Q180 + phi;
        end
        else
        begin
            t = cf.yneg ? phi : Q360 - phi;
        end
        priority if (cf.xzero)
        begin
            angle_next = cf.yzero ? ANG_W'(180) : (cf.yneg ? ANG_W'(90) : ANG_W'(270));
        end
        else if (cf.yzero)
        begin
            angle_next = cf.xneg ? ANG_W'(360) : ANG_W'(180);
        end
        else
        begin
            angle_next = t[FRAC +: ANG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

@@ sv/accel_tilt_angles_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Three tilt angles from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries x, y and z readings; a request is taken when s_tvalid and
//   s_tready are both high. m_tdata returns angle_yz, angle_xz and angle_yx in
//   whole degrees (0..360); m_tuser is the calibration error flag, and with
//   it set all angles read zero.
//   The cfg port writes cal_low (index 0) and cal_high (index 1); write them
//   only while no request is in flight.
// Timing:
//   One request per clock while s_tready is high. The pipe holds one input
//   stage, SAMPLE_BITS + 8 divider cells that each settle one quotient bit,
//   a mapping stage, a CORDIC entry stage, one cell per CORDIC step and an
//   output stage.
// Reset:
//   The pipe empties and calibration returns to 265 and 402.
// Stall:
//   A result that is not taken moves to a skid register; the pipe keeps
//   running for that cycle, then holds until the skid register drains.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core import atl_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // x_raw, y_raw, z_raw, zero fill
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // angle_yz, angle_xz, angle_yx, zero fill
    output logic [31:0]                           m_tdata,
    // cal_error
    output logic                                  m_tuser,
    input  logic                                  cfg_we,
    input  logic                                  cfg_addr,
    input  logic [SAMPLE_BITS-1:0]                cfg_wdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int QW    = SB + 8;
    localparam int AW    = SB + 10;
    localparam int DEPTH = QW + CORDIC_STEPS + 4;

    logic [SB-1:0] cal_low_reg, cal_high_reg, span;
    logic [DEPTH-1:0] vld_reg;
    logic en, cal_err;
    logic signed [AW-1:0] ax, ay, az;
    logic [ANG_W-1:0] ang_yz, ang_xz, ang_yx;
    logic [3*ANG_W-1:0] skid_reg, res;
    logic skid_vld_reg;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= SB'(CAL_LOW_RESET);
            cal_high_reg <= SB'(CAL_HIGH_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CAL_LOW:  cal_low_reg  <= cfg_wdata;
                REG_CAL_HIGH: cal_high_reg <= cfg_wdata;
                default:      cal_low_reg  <= cal_low_reg;
            endcase
        end
    end

    assign span    = cal_high_reg - cal_low_reg;
    assign cal_err = (cal_high_reg <= cal_low_reg);
    assign en      = !skid_vld_reg;
    assign s_tready = en;

    // Per-axis mapping.
    atl_axis_map #(.SB(SB), .QW(QW), .AW(AW)) u_map_x (
        .clk(clk), .en(en), .raw(s_tdata[0 +: SB]), .cal_low(cal_low_reg),
        .span(span), .mapped(ax)
    );
    atl_axis_map #(.SB(SB), .QW(QW), .AW(AW)) u_map_y (
        .clk(clk), .en(en), .raw(s_tdata[SB +: SB]), .cal_low(cal_low_reg),
        .span(span), .mapped(ay)
    );
    atl_axis_map #(.SB(SB), .QW(QW), .AW(AW)) u_map_z (
        .clk(clk), .en(en), .raw(s_tdata[2*SB +: SB]), .cal_low(cal_low_reg),
        .span(span), .mapped(az)
    );

    // Angle per axis pair.
    atl_tilt #(.AW(AW), .N(CORDIC_STEPS)) u_tilt_yz (
        .clk(clk), .en(en), .p(ay), .q(az), .angle(ang_yz)
    );
    atl_tilt #(.AW(AW), .N(CORDIC_STEPS)) u_tilt_xz (
        .clk(clk), .en(en), .p(ax), .q(az), .angle(ang_xz)
    );
    atl_tilt #(.AW(AW), .N(CORDIC_STEPS)) u_tilt_yx (
        .clk(clk), .en(en), .p(ay), .q(ax), .angle(ang_yx)
    );

    // Valid bits that travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    assign res = {ang_yx, ang_xz, ang_yz};

    // Skid register that catches a result the receiver does not take.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (m_tready)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (vld_reg[DEPTH-1] && !m_tready)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = skid_vld_reg || vld_reg[DEPTH-1];
    assign m_tdata  = cal_err ? '0 : {5'b0, (skid_vld_reg ? skid_reg : res)};
    assign m_tuser  = cal_err;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerometer tilt angle core.
// ----------------------------------------------------------------------------
// Samples are sent over the input stream under several calibration settings.
// A bit-accurate model of the mapping and the CORDIC arctangent predicts the
// three angles and the error flag of every request. Each result is compared
// with the oldest prediction, with random gaps on the input side and random
// stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
    import atl_pkg::*;

    localparam int SB = 10;
    localparam int STEPS = 16;
    localparam int LATENCY = SB + STEPS + 12;
    localparam int DW = ((3*SB+7)/8)*8;

    typedef struct packed {
        logic [8:0] yz;
        logic [8:0] xz;
        logic [8:0] yx;
        logic       err;
    } tilt_res_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [31:0]   m_tdata;
    logic          m_tuser;
    logic          cfg_we = 1'b0;
    logic          cfg_addr = REG_CAL_LOW;
    logic [SB-1:0] cfg_wdata = '0;

    // Model copy of the calibration registers.
    logic [SB-1:0] span_lo;
    logic [SB-1:0] span_hi;

    tilt_res_t angle_queue[$];
    int        mismatches = 0;
    int        hold_off = 0;
    bit        stall_enable = 1'b1;

    accel_tilt_angles_core #(.CORDIC_STEPS(STEPS), .SAMPLE_BITS(SB)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Arithmetic right shift toward minus infinity.
    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    // Reduced first-quadrant angle in Q16 degrees.
    function automatic longint quad_angle(longint ax, longint ay);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        if (ax == ay)
            return 64'd45 << 16;
        x = ax <<< 16;
        y = ay <<< 16;
        z = 0;
        for (int i = 0; i < STEPS && i < TAB_LEN; i++)
        begin
            if (y > 0)
            begin
                nx = x + shr(y, i);
                ny = y - shr(x, i);
                z += longint'(ATAN_Q16[i]);
            end
            else
            begin
                nx = x - shr(y, i);
                ny = y + shr(x, i);
                z -= longint'(ATAN_Q16[i]);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > (64'd90 << 16))
            z = 64'd90 << 16;
        return z;
    endfunction

    // Whole degrees of atan2(yv, xv) + 180.
    function automatic logic [8:0] tilt_deg(longint yv, longint xv);
        longint phi;
        longint t;
        if (xv == 0)
            return (yv > 0) ? 9'd270 : (yv < 0) ? 9'd90 : 9'd180;
        if (yv == 0)
            return (xv > 0) ? 9'd180 : 9'd360;
        phi = quad_angle(xv < 0 ? -xv : xv, yv < 0 ? -yv : yv);
        if (xv > 0)
            t = (yv > 0) ? (64'd180 << 16) + phi : (64'd180 << 16) - phi;
        else
            t = (yv > 0) ? (64'd360 << 16) - phi : phi;
        if (t < 0)
            t = 0;
        return 9'(t / 65536);
    endfunction

    // Linear: span_lo to -90, span_hi to 90, quotient truncated toward zero.
    function automatic longint map_reading(logic [SB-1:0] r);
        longint num;
        longint den;
        num = (longint'(r) - longint'(span_lo)) * 180;
        den = longint'(span_hi) - longint'(span_lo);
        return num / den - 90;
    endfunction

    function automatic tilt_res_t predict_angles(logic [SB-1:0] xr, logic [SB-1:0] yr,
                                                 logic [SB-1:0] zr);
        tilt_res_t r;
        longint xa;
        longint ya;
        longint za;
        if (span_hi <= span_lo)
            return '{yz: 9'd0, xz: 9'd0, yx: 9'd0, err: 1'b1};
        xa = map_reading(xr);
        ya = map_reading(yr);
        za = map_reading(zr);
        r.yz = tilt_deg(-ya, -za);
        r.xz = tilt_deg(-xa, -za);
        r.yx = tilt_deg(-ya, -xa);
        r.err = 1'b0;
        return r;
    endfunction

    // Send one sample request and record its prediction; tvalid stays high
    // until the caller offers the next request or idles the input.
    task automatic send_sample(logic [SB-1:0] xr, logic [SB-1:0] yr, logic [SB-1:0] zr);
        s_tvalid <= 1'b1;
        s_tdata <= DW'({zr, yr, xr});
        do
            @(posedge clk);
        while (!s_tready);
        angle_queue.push_back(predict_angles(xr, yr, zr));
    endtask

    // Random bursts with random gaps.
    task automatic send_random(int count, int lo, int hi);
        int burst;
        int gap;
        while (count > 0)
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && count > 0; k++, count--)
                send_sample(SB'($urandom_range(lo, hi)), SB'($urandom_range(lo, hi)),
                            SB'($urandom_range(lo, hi)));
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_cal(logic [SB-1:0] lo, logic [SB-1:0] hi);
        cfg_we <= 1'b1;
        cfg_addr <= REG_CAL_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr <= REG_CAL_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        span_lo = lo;
        span_hi = hi;
    endtask

    // Extremes and equal magnitudes at reset calibration.
    task automatic test_directed();
        send_sample(10'd0, 10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023, 10'd1023);
        send_sample(10'd0, 10'd1023, 10'd512);
        send_sample(10'd1023, 10'd0, 10'd333);
        send_sample(10'd333, 10'd333, 10'd333);   // all map to -1
        send_sample(10'd333, 10'd400, 10'd333);
        send_sample(10'd333, 10'd266, 10'd333);
        send_sample(10'd400, 10'd333, 10'd266);
        send_sample(10'd266, 10'd333, 10'd400);
        send_sample(10'd265, 10'd402, 10'd265);
        send_sample(10'd402, 10'd265, 10'd402);
        send_sample(10'd300, 10'd300, 10'd366);   // equal magnitudes
        send_sample(10'd300, 10'd366, 10'd300);
        send_sample(10'd682, 10'd341, 10'd170);
        send_sample(10'd511, 10'd512, 10'd1);
        wait_drained();
    endtask

    task automatic test_reset_cal();
        send_random(500, 200, 470);
        send_random(150, 0, 1023);
        wait_drained();
    endtask

    task automatic test_full_span();
        write_cal(10'd0, 10'd1023);
        send_random(300, 0, 1023);
        wait_drained();
        write_cal(10'd1022, 10'd1023);
        send_sample(10'd0, 10'd1023, 10'd1022);
        send_random(100, 0, 1023);
        wait_drained();
        write_cal(10'd500, 10'd501);
        send_random(100, 450, 550);
        wait_drained();
    endtask

    task automatic test_bad_cal();
        write_cal(10'd402, 10'd265);
        send_random(60, 0, 1023);
        wait_drained();
        write_cal(10'd1023, 10'd1023);
        send_random(40, 0, 1023);
        wait_drained();
        write_cal(10'd0, 10'd0);
        send_random(20, 0, 1023);
        wait_drained();
    endtask

    // The receiver holds off long enough for the pipe to fill and stall.
    task automatic test_backpressure();
        write_cal(10'd100, 10'd900);
        hold_off = 4 * LATENCY;
        send_random(200, 0, 1023);
        wait_drained();
        stall_enable = 1'b0;
        send_random(200, 0, 1023);
        wait_drained();
        stall_enable = 1'b1;
        write_cal(SB'($urandom_range(0, 500)), SB'($urandom_range(501, 1023)));
        send_random(300, 0, 1023);
        wait_drained();
    endtask

    // Receiver readiness: a hold-off on request, else ready or random stalls.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (!stall_enable)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 9) > 2);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        tilt_res_t want;
        tilt_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{yz: m_tdata[8:0], xz: m_tdata[17:9], yx: m_tdata[26:18], err: m_tuser};
            if (angle_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = angle_queue.pop_front();
                if (got !== want || m_tdata[31:27] !== 5'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p (tdata %h)",
                                 want, got, m_tdata);
                end
            end
        end
    end

    initial
    begin
        span_lo = 10'(CAL_LOW_RESET);
        span_hi = 10'(CAL_HIGH_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reset_cal();
        test_full_span();
        test_bad_cal();
        test_backpressure();
        if (mismatches == 0 && angle_queue.size() == 0)
            $display("accel_tilt_angles_core verification clean");
        else
            $display("accel_tilt_angles_core verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("accel_tilt_angles_core verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/atl_pkg.sv
sv/atl_div_cell.sv
sv/atl_axis_map.sv
sv/atl_cordic_cell.sv
sv/atl_tilt.sv
sv/accel_tilt_angles_core.sv
tb/sv/tb.sv
